// ===== design/brb_pkg.sv =====
// Shared types and codes for the byte ring buffer.
`timescale 1ns / 1ps

package brb_pkg;

   // Operation codes carried by a request word
   typedef enum logic [2:0] {
      MODE_PUSH  = 3'd0,
      MODE_POP   = 3'd1,
      MODE_PEEK  = 3'd2,
      MODE_POKE  = 3'd3,
      MODE_SKIP  = 3'd4,
      MODE_CLEAR = 3'd5
   } mode_type;

   // Completion codes carried by a response word
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // One request word as latched by the controller
   typedef struct packed {
      mode_type    mode;
      logic [7:0]  write_byte;
      logic [11:0] offset;
      logic [12:0] skip_count;
   } item_type;

   // Outcome of one operation, passed from the pointer unit to the controller
   typedef struct packed {
      status_type  status;
      logic        rd_ok;
      logic [11:0] avail;
      logic [11:0] free;
   } outcome_type;

endpackage

// ===== design/brb_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/brb_ptr.sv =====
// Pointer unit: capacity register, head and tail pointers, fill count and status.
`timescale 1ns / 1ps

module brb_ptr
   import brb_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [12:0]       csr_wr_data,
   input  logic              exec,
   input  item_type          item,
   output logic              mem_we,
   output logic [AW-1:0]     mem_addr,
   output outcome_type       outcome
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = ((CW > 13) ? CW : 13) + 1;

   logic [CW-1:0] cap_ff, cap_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] avail_ff, avail_in;

   logic [EW-1:0] cap_e, avail_e, addend_e, sum_e, pos_e, wr_e, clamp_e;
   logic [AW-1:0] head_inc, tail_inc, pos;

   assign cap_e   = EW'(cap_ff);
   assign avail_e = EW'(avail_ff);

   // Share one adder between peek/poke position and skip target
   assign addend_e = (item.mode == MODE_SKIP) ? EW'(item.skip_count) : EW'(item.offset);
   assign sum_e    = EW'(head_ff) + addend_e;
   assign pos_e    = (sum_e >= cap_e) ? (sum_e - cap_e) : sum_e;
   assign pos      = pos_e[AW-1:0];

   // Advance pointers by one with wrap at the capacity
   assign head_inc = (CW'(head_ff) == (cap_ff - 1'b1)) ? '0 : (head_ff + 1'b1);
   assign tail_inc = (CW'(tail_ff) == (cap_ff - 1'b1)) ? '0 : (tail_ff + 1'b1);

   // Clamp a written capacity into the legal range
   assign wr_e    = EW'(csr_wr_data);
   assign clamp_e = (wr_e < EW'(2)) ? EW'(2) :
                    ((wr_e > EW'(DEPTH)) ? EW'(DEPTH) : wr_e);

   always_comb begin
      cap_in          = cap_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      avail_in        = avail_ff;
      mem_we          = 1'b0;
      mem_addr        = pos;
      outcome.status  = ST_OK;
      outcome.rd_ok   = 1'b0;

      if (csr_wr_en) begin
         // Resize implies a clear
         cap_in   = clamp_e[CW-1:0];
         head_in  = '0;
         tail_in  = '0;
         avail_in = '0;
      end else if (exec) begin
         unique case (item.mode)
            MODE_PUSH: begin
               if ((avail_e + EW'(1)) == cap_e) begin
                  outcome.status = ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  mem_addr = tail_ff;
                  tail_in  = tail_inc;
                  avail_in = avail_ff + 1'b1;
               end
            end
            MODE_POP: begin
               if (avail_ff == '0) begin
                  outcome.status = ST_EMPTY;
               end else begin
                  mem_addr      = head_ff;
                  outcome.rd_ok = 1'b1;
                  head_in       = head_inc;
                  avail_in      = avail_ff - 1'b1;
               end
            end
            MODE_PEEK, MODE_POKE: begin
               if (EW'(item.offset) >= avail_e) begin
                  outcome.status = ST_RANGE;
               end else if (item.mode == MODE_PEEK) begin
                  outcome.rd_ok = 1'b1;
               end else begin
                  mem_we = 1'b1;
               end
            end
            MODE_SKIP: begin
               if (item.skip_count == '0) begin
                  outcome.status = ST_RANGE;
               end else if (EW'(item.skip_count) > avail_e) begin
                  outcome.status = ST_EMPTY;
               end else begin
                  head_in  = pos;
                  avail_in = avail_ff - AW'(item.skip_count);
               end
            end
            MODE_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               avail_in = '0;
            end
            default: begin
               // Unused codes leave everything unchanged
            end
         endcase
      end

      // Report fill counts after the operation
      outcome.avail = 12'(avail_in);
      outcome.free  = 12'(cap_e - EW'(avail_in) - EW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CW'(DEPTH);
         head_ff  <= '0;
         tail_ff  <= '0;
         avail_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         avail_ff <= avail_in;
      end
   end

endmodule

// ===== design/byte_ring_buffer_peek_poke_top.sv =====
// Top level of the byte ring buffer with push, pop, peek, poke, skip and clear.
//
// Request channel: drive req_* and raise start; the word is taken at a rising edge
// with start high and busy low. Busy is high in the cycle after a request is
// taken, so a new request is not taken while the previous one executes.
// Response channel: rsp_valid is high for exactly one cycle, registered as the
// busy cycle ends, carrying read_byte, status and the fill counts after the
// operation. The receiver cannot stall the response; it must take it then.
// Timing is set by the byte store: the operation is decoded and the store is
// read or written in the cycle after acceptance, and read data comes out of the
// store's output register in the following cycle, which is the response cycle.
// Configuration: csr_wr_en with csr_wr_data writes the ring capacity (clamped to
// 2..DEPTH) and empties the ring; write it only while no request is in flight.
// Reset (synchronous, active high) empties the ring and sets capacity to DEPTH.
// Store contents are not cleared; only bytes pushed since the last clear are read.
`timescale 1ns / 1ps

module byte_ring_buffer_peek_poke_top
   import brb_pkg::*;
#(
   parameter int DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_write_byte,
   input  logic [11:0] req_offset,
   input  logic [12:0] req_skip_count,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_byte,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_avail_count,
   output logic [11:0] rsp_free_count,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);

   localparam int AW = $clog2(DEPTH);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   item_type    item_ff, item_in;
   outcome_type res_ff, res_in;

   logic        accept;
   logic        exec;
   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]  mem_rdata;
   outcome_type outcome;

   assign accept = start && (state_ff == S_IDLE);
   assign exec   = (state_ff == S_EXEC);

   // Latch the request word, run it in the next cycle, present the result after
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      item_in      = item_ff;
      res_in       = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in.mode       = mode_type'(req_mode);
               item_in.write_byte = req_write_byte;
               item_in.offset     = req_offset;
               item_in.skip_count = req_skip_count;
               state_in           = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in       = outcome;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   brb_ptr #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ptr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .exec        (exec),
      .item        (item_ff),
      .mem_we      (mem_we),
      .mem_addr    (mem_addr),
      .outcome     (outcome)
   );

   brb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (item_ff.write_byte),
      .rdata (mem_rdata)
   );

   // Drive response ports; read data comes straight from the store register
   assign busy            = exec;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_byte   = res_ff.rd_ok ? mem_rdata : 8'h00;
   assign rsp_status      = res_ff.status;
   assign rsp_avail_count = res_ff.avail;
   assign rsp_free_count  = res_ff.free;

endmodule

// ===== design/brb_checker.sv =====
// Port-level checker for the byte ring buffer top level, bound into it.
`timescale 1ns / 1ps

module brb_checker
   import brb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [7:0]  rsp_read_byte,
   input logic [1:0]  rsp_status,
   input logic [11:0] rsp_free_count
);

   // Taking a request word makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request word taken");

   // Every busy cycle is followed by exactly one response word
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("response word missing after busy cycle");

   // Response words never come in consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   // Failed operations return no data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_read_byte == 8'h00))
      else $error("failed operation returned data");

   // A full push reports no free room
   a_full_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_free_count == 12'd0))
      else $error("full status with nonzero free count");

endmodule

bind byte_ring_buffer_peek_poke_top brb_checker u_checker (.*);

// ===== verif/tb_byte_ring_buffer_peek_poke_top.sv =====
// Testbench for the byte ring buffer: checks each response word against a ring predictor.
`timescale 1ns / 1ps

module tb_byte_ring_buffer_peek_poke_top;
   import brb_pkg::*;

   localparam int DEPTH = 4096;

   // One request word as queued for the driver
   typedef struct {
      logic [2:0]  mode;
      logic [7:0]  wbyte;
      logic [11:0] offset;
      logic [12:0] count;
   } ring_op_type;

   // One predicted response word
   typedef struct {
      logic [7:0]  rbyte;
      status_type  status;
      logic [11:0] avail;
      logic [11:0] free;
   } ring_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_mode = '0;
   logic [7:0]  req_write_byte = '0;
   logic [11:0] req_offset = '0;
   logic [12:0] req_skip_count = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_byte;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_avail_count;
   logic [11:0] rsp_free_count;
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;

   // Predictor copy of the ring
   logic [7:0]  ring_mem [DEPTH];
   int unsigned rd_ptr = 0;
   int unsigned wr_ptr = 0;
   int unsigned ring_cap = DEPTH;

   ring_op_type  pending_ops [$];
   ring_rsp_type expected_rsps [$];
   logic        req_taken = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned phase_cap = DEPTH;
   int          err_count = 0;

   byte_ring_buffer_peek_poke_top #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_write_byte(req_write_byte),
      .req_offset(req_offset),
      .req_skip_count(req_skip_count),
      .rsp_valid(rsp_valid),
      .rsp_read_byte(rsp_read_byte),
      .rsp_status(rsp_status),
      .rsp_avail_count(rsp_avail_count),
      .rsp_free_count(rsp_free_count),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clamp a capacity write into 2..DEPTH
   function automatic int unsigned cap_clamp(logic [12:0] v);
      if (v < 2) return 2;
      if (v > DEPTH) return DEPTH;
      return v;
   endfunction

   // Bytes held between the read and write pointers
   function automatic int unsigned ring_fill();
      if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
      return wr_ptr + ring_cap - rd_ptr;
   endfunction

   // Apply one request word to the predictor and return its response word
   function automatic ring_rsp_type ring_execute(ring_op_type op);
      ring_rsp_type r;
      int unsigned held;
      int unsigned pos;
      held = ring_fill();
      r.rbyte = '0;
      r.status = ST_OK;
      case (op.mode)
         MODE_PUSH: begin
            if (ring_cap - held - 1 == 0) begin
               r.status = ST_FULL;
            end else begin
               ring_mem[wr_ptr] = op.wbyte;
               wr_ptr = (wr_ptr + 1) % ring_cap;
            end
         end
         MODE_POP: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.rbyte = ring_mem[rd_ptr];
               rd_ptr = (rd_ptr + 1) % ring_cap;
            end
         end
         MODE_PEEK, MODE_POKE: begin
            if (int'(op.offset) + 1 > held) begin
               r.status = ST_RANGE;
            end else begin
               pos = (rd_ptr + op.offset) % ring_cap;
               if (op.mode == MODE_PEEK) r.rbyte = ring_mem[pos];
               else ring_mem[pos] = op.wbyte;
            end
         end
         MODE_SKIP: begin
            if (op.count == 0) r.status = ST_RANGE;
            else if (op.count > held) r.status = ST_EMPTY;
            else rd_ptr = (rd_ptr + op.count) % ring_cap;
         end
         MODE_CLEAR: begin
            rd_ptr = 0;
            wr_ptr = 0;
         end
         default: begin
         end
      endcase
      held = ring_fill();
      r.avail = held[11:0];
      r.free = 12'(ring_cap - held - 1);
      return r;
   endfunction

   // Compare one response field and report a mismatch
   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
         err_count++;
      end
   endtask

   // Driver: present the next word at the falling edge, hold it until taken
   always @(negedge clock) begin
      ring_op_type op;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            op = pending_ops.pop_front();
            start <= 1'b1;
            req_mode <= op.mode;
            req_write_byte <= op.wbyte;
            req_offset <= op.offset;
            req_skip_count <= op.count;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: track config writes, predict taken words, check response words
   always @(posedge clock) begin
      ring_op_type  seen;
      ring_rsp_type want;
      if (reset) begin
         rd_ptr = 0;
         wr_ptr = 0;
         ring_cap = DEPTH;
         req_taken <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ring_cap = cap_clamp(csr_wr_data);
            rd_ptr = 0;
            wr_ptr = 0;
         end
         // check older responses before queueing this edge's word
         if (rsp_valid === 1'b1) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response word with nothing expected", $time);
               err_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("read_byte", want.rbyte, rsp_read_byte);
               check_field("status", want.status, rsp_status);
               check_field("avail_count", want.avail, rsp_avail_count);
               check_field("free_count", want.free, rsp_free_count);
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) begin
            seen.mode = req_mode;
            seen.wbyte = req_write_byte;
            seen.offset = req_offset;
            seen.count = req_skip_count;
            expected_rsps.push_back(ring_execute(seen));
         end
      end
   end

   task automatic queue_op(logic [2:0] mode, logic [7:0] wbyte, logic [11:0] offset,
                           logic [12:0] count);
      ring_op_type op;
      op.mode = mode;
      op.wbyte = wbyte;
      op.offset = offset;
      op.count = count;
      pending_ops.push_back(op);
   endtask

   // Wait until every word is sent and every response has come back
   task automatic drain_ring();
      int waited;
      waited = 0;
      // sample at the rising edge, where the driver's outputs are settled
      do @(posedge clock); while (pending_ops.size() > 0 || start);
      @(negedge clock);
      while (expected_rsps.size() > 0 && waited < 50) begin
         @(negedge clock);
         waited++;
      end
      if (expected_rsps.size() > 0) begin
         $display("%0t: %0d expected response words never arrived", $time,
                  expected_rsps.size());
         err_count += expected_rsps.size();
         expected_rsps.delete();
      end
   endtask

   // Write the capacity register once the ring is idle
   task automatic write_capacity(logic [12:0] v);
      drain_ring();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      phase_cap = cap_clamp(v);
   endtask

   // Set a capacity and sender idling, then queue random words
   task automatic run_random_phase(logic [12:0] cap_value, int unsigned idle_pct, int n);
      int unsigned pick;
      int unsigned lim;
      logic [2:0]  mode;
      logic [11:0] offset;
      logic [12:0] count;
      write_capacity(cap_value);
      send_idle_pct = idle_pct;
      lim = (phase_cap - 1 < 40) ? phase_cap - 1 : 40;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 34) mode = MODE_PUSH;
         else if (pick < 54) mode = MODE_POP;
         else if (pick < 68) mode = MODE_PEEK;
         else if (pick < 80) mode = MODE_POKE;
         else if (pick < 89) mode = MODE_SKIP;
         else if (pick < 95) mode = MODE_CLEAR;
         else mode = 3'($urandom_range(6, 7));
         // mostly small offsets and counts within the capacity, some anywhere in the field
         if ($urandom_range(0, 3) != 0) offset = 12'($urandom_range(0, lim));
         else offset = 12'($urandom_range(0, 4095));
         pick = $urandom_range(0, 9);
         if (pick == 0) count = '0;
         else if (pick < 8) count = 13'($urandom_range(1, (phase_cap < 8) ? phase_cap : 8));
         else count = 13'($urandom_range(0, 8191));
         queue_op(mode, 8'($urandom_range(0, 255)), offset, count);
      end
   endtask

   // Stimulus: reset, directed words, then random phases
   initial begin
      for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // empty ring errors at reset capacity
      queue_op(MODE_POP, 8'h00, 12'd0, 13'd0);
      queue_op(MODE_PEEK, 8'h00, 12'd0, 13'd0);
      queue_op(MODE_SKIP, 8'h00, 12'd0, 13'd0);
      queue_op(MODE_SKIP, 8'h00, 12'd0, 13'h1FFF);
      // fill, peek and poke in and out of range, pop two of the three bytes
      queue_op(MODE_PUSH, 8'h00, 12'd0, 13'd0);
      queue_op(MODE_PUSH, 8'hFF, 12'd0, 13'd0);
      queue_op(MODE_PUSH, 8'hA5, 12'd0, 13'd0);
      queue_op(MODE_PEEK, 8'h00, 12'd0, 13'd0);
      queue_op(MODE_PEEK, 8'h00, 12'd2, 13'd0);
      queue_op(MODE_PEEK, 8'h00, 12'd3, 13'd0);
      queue_op(MODE_POKE, 8'h77, 12'hFFF, 13'd0);
      queue_op(MODE_POKE, 8'h5A, 12'd1, 13'd0);
      queue_op(MODE_POP, 8'h00, 12'd0, 13'd0);
      queue_op(MODE_POP, 8'h00, 12'd0, 13'd0);
      // unused codes, then clear with a byte still held
      queue_op(3'd6, 8'hFF, 12'hFFF, 13'h1FFF);
      queue_op(3'd7, 8'hFF, 12'hFFF, 13'h1FFF);
      queue_op(MODE_CLEAR, 8'h00, 12'd0, 13'd0);

      // smallest ring via a clamped write: full, wrap, skip
      write_capacity(13'd0);
      queue_op(MODE_PUSH, 8'h3C, 12'd0, 13'd0);
      queue_op(MODE_PUSH, 8'hC3, 12'd0, 13'd0);
      queue_op(MODE_PEEK, 8'h00, 12'd0, 13'd0);
      queue_op(MODE_SKIP, 8'h00, 12'd0, 13'd1);
      queue_op(MODE_PUSH, 8'h81, 12'd0, 13'd0);
      queue_op(MODE_POP, 8'h00, 12'd0, 13'd0);
      queue_op(MODE_POP, 8'h00, 12'd0, 13'd0);
      queue_op(MODE_SKIP, 8'h00, 12'd0, 13'd1);

      run_random_phase(13'd2, 0, 100);
      run_random_phase(13'($urandom_range(3, 16)), 88, 100);
      run_random_phase(13'h1FFF, 0, 100);
      run_random_phase(13'($urandom_range(17, 64)), 8, 100);
      run_random_phase(13'd1, 0, 100);

      drain_ring();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hard stop for a hung run
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
